/* hdl/wtft_pkg.sv */
// Package for the weight table feedback tuner: item types, constants and helpers.
package wtft_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned INDEX_VALUES    = 256;
  localparam int unsigned WEIGHT_W        = 32;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CLAMP_W         = 40;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT    = 2'd2;

  localparam logic [15:0]        LEARNING_RATE_RST = 16'd6554;
  localparam logic signed [31:0] MIN_WEIGHT_RST    = 32'sd0;
  localparam logic signed [31:0] MAX_WEIGHT_RST    = 32'sd655360;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] NEG_ONE_Q14 = -16'sd16384;

  typedef struct packed {
    logic [7:0]         weight_index;
    logic signed [15:0] feedback;
    logic signed [15:0] smoothing;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         result_index;
    logic signed [31:0] new_weight;
  } out_item_t;

  // when the bounds cross, values below min give min and all others give max
  function automatic logic signed [WEIGHT_W-1:0] clamp_weight(
    input logic signed [CLAMP_W-1:0]  v,
    input logic signed [WEIGHT_W-1:0] mn,
    input logic signed [WEIGHT_W-1:0] mx
  );
    logic signed [CLAMP_W-1:0] mn_ext;
    logic signed [CLAMP_W-1:0] mx_ext;
    mn_ext = CLAMP_W'(mn);
    mx_ext = CLAMP_W'(mx);
    if (v < mn_ext) begin
      return mn;
    end else if (v > mx_ext) begin
      return mx;
    end
    return v[WEIGHT_W-1:0];
  endfunction

endpackage

/* hdl/wtft_stream_if.sv */
// Valid/ready stream interface carrying one payload per transaction.
interface wtft_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/wtft_ram.sv */
// Generic simple dual-port RAM with registered read.
module wtft_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/weight_table_feedback_tuner_top.sv */
// Weight table feedback tuner: top level with sequencer, datapath and table.
//
// Usage: in_i carries one transaction per update (weight_index, feedback,
// smoothing); out_o returns one transaction per update (result_index,
// new_weight). Both are valid/ready streams. The index wraps modulo
// TABLE_DEPTH. Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// while no update is in flight; index 0 is learning_rate, 1 min_weight,
// 2 max_weight, others are ignored.
// Updates are handled one at a time: a new input is accepted only once the
// previous one is written back, after the single weight RAM
// read-modify-write and the multiply/round/clamp chain behind it
// (rate*feedback, weight*product, round, clamp, blend multiply, sum,
// round and clamp with write-back).
// Reset: registers take their defaults and every entry reads as 1.0 until
// written; the block is ready in the first cycle after reset.
// Stall: one result is held in the output register; the next input is
// accepted meanwhile, and write-back waits until that result is taken.
module weight_table_feedback_tuner_top
  import wtft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  wtft_stream_if.sink           in_i,
  wtft_stream_if.source         out_o
);
  localparam int unsigned IDX_W    = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned USED     = TABLE_DEPTH < INDEX_VALUES ? TABLE_DEPTH : INDEX_VALUES;
  localparam int unsigned VIDX_W   = USED > 1 ? $clog2(USED) : 1;

  localparam logic signed [63:0] RND30_POS = 64'sd536870912;
  localparam logic signed [63:0] RND30_NEG = 64'sd536870911;
  localparam logic signed [48:0] RND14_POS = 49'sd8192;
  localparam logic signed [48:0] RND14_NEG = 49'sd8191;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DELTA  = 3'd2;
  localparam logic [2:0] ST_TARGET = 3'd3;
  localparam logic [2:0] ST_BLEND  = 3'd4;
  localparam logic [2:0] ST_SUM    = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;

  in_item_t in_item;
  assign in_item = in_i.data;

  // configuration
  logic [15:0]        lr_q;
  logic signed [31:0] min_q;
  logic signed [31:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LEARNING_RATE_RST;
      min_q <= MIN_WEIGHT_RST;
      max_q <= MAX_WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEARNING_RATE: lr_q  <= cfg_data_i[15:0];
        REG_MIN_WEIGHT:    min_q <= $signed(cfg_data_i);
        REG_MAX_WEIGHT:    max_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // index wrap table
  logic [IDX_W-1:0] idx_tab [INDEX_VALUES];
  for (genvar i = 0; i < INDEX_VALUES; i++) begin : g_idx_tab
    assign idx_tab[i] = IDX_W'(i % TABLE_DEPTH);
  end

  logic [2:0] state_q, state_d;
  logic       in_fire;
  logic       final_fire;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // input capture
  logic [IDX_W-1:0]   idx_in;
  logic signed [15:0] fb_c;
  logic [14:0]        s_c;
  logic signed [32:0] rf_full;

  assign idx_in = idx_tab[in_item.weight_index];

  always_comb begin
    if (in_item.feedback > ONE_Q14) begin
      fb_c = ONE_Q14;
    end else if (in_item.feedback < NEG_ONE_Q14) begin
      fb_c = NEG_ONE_Q14;
    end else begin
      fb_c = in_item.feedback;
    end
    if (in_item.smoothing > ONE_Q14) begin
      s_c = 15'(ONE_Q14);
    end else if (in_item.smoothing < 16'sd0) begin
      s_c = '0;
    end else begin
      s_c = in_item.smoothing[14:0];
    end
    rf_full = $signed({1'b0, lr_q}) * fb_c;
  end

  logic [IDX_W-1:0]   idx_q;
  logic [14:0]        s_q;
  logic signed [31:0] rf_q;
  logic               valid_q;
  logic               written_q [USED];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      idx_q   <= idx_in;
      s_q     <= s_c;
      rf_q    <= rf_full[31:0];
      valid_q <= written_q[VIDX_W'(idx_in)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < USED; i++) begin
        written_q[i] <= 1'b0;
      end
    end else if (final_fire) begin
      written_q[VIDX_W'(idx_q)] <= 1'b1;
    end
  end

  // weight table
  logic [WEIGHT_W-1:0]        ram_rdata;
  logic signed [WEIGHT_W-1:0] result_w;

  wtft_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (final_fire),
    .waddr_i (idx_q),
    .wdata_i (result_w),
    .re_i    (in_fire),
    .raddr_i (idx_in),
    .rdata_o (ram_rdata)
  );

  // datapath
  logic signed [31:0] cur_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] delta_q;
  logic signed [31:0] target_q;
  logic signed [48:0] bprod_q;
  logic signed [48:0] sum_q;

  logic signed [31:0] cur_d;
  logic signed [63:0] dsum;
  logic signed [CLAMP_W-1:0] tsum;
  logic signed [32:0] diff;
  logic signed [48:0] bprod_d;
  logic signed [48:0] cur_ext;
  logic signed [48:0] rsum;
  logic signed [CLAMP_W-1:0] rnd;

  always_comb begin
    cur_d   = valid_q ? $signed(ram_rdata) : ONE_Q16;
    dsum    = prod_q + (prod_q[63] ? RND30_NEG : RND30_POS);
    tsum    = CLAMP_W'(cur_q) + CLAMP_W'(delta_q);
    diff    = 33'(target_q) - 33'(cur_q);
    bprod_d = diff * $signed({1'b0, s_q});
    cur_ext = 49'(cur_q);
    rsum    = sum_q + (sum_q[48] ? RND14_NEG : RND14_POS);
    rnd     = CLAMP_W'($signed(rsum[48:14]));
    result_w = clamp_weight(rnd, min_q, max_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL: begin
        cur_q  <= cur_d;
        prod_q <= cur_d * rf_q;
      end
      ST_DELTA:  delta_q  <= dsum[63:30];
      ST_TARGET: target_q <= clamp_weight(tsum, min_q, max_q);
      ST_BLEND:  bprod_q  <= bprod_d;
      ST_SUM:    sum_q    <= bprod_q + (cur_ext <<< 14);
      default: ;
    endcase
  end

  // sequencer
  assign final_fire = (state_q == ST_FINAL) && (!out_o.valid || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DELTA;
      ST_DELTA:  state_d = ST_TARGET;
      ST_TARGET: state_d = ST_BLEND;
      ST_BLEND:  state_d = ST_SUM;
      ST_SUM:    state_d = ST_FINAL;
      ST_FINAL:  if (final_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  always_comb begin
    if (final_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (final_fire) begin
      out_data_q.result_index <= 8'(idx_q);
      out_data_q.new_weight   <= result_w;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL))
    else $error("accepted transaction did not start processing");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (32'(out_data_q.result_index) < TABLE_DEPTH))
    else $error("result index beyond table");

  a_weight_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (min_q <= max_q)) |->
      ((out_data_q.new_weight >= min_q) && (out_data_q.new_weight <= max_q)))
    else $error("result weight outside bounds");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_fire |=> (state_q == ST_IDLE) && out_o.valid)
    else $error("write-back did not present a result");
`endif

endmodule
